// ===== hw/rtl/horc_pkg.sv =====
// Package for the hashed operation result cache.
// Holds the transaction structs, command codes, FNV constants and the controller states.
package horc_pkg;

  localparam logic [63:0] FnvPrime = 64'd1099511628211;
  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam int unsigned TagW = 14;
  localparam int unsigned TagLsb = 48;

  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key_first;
    logic [63:0] key_second;
    logic [63:0] key_third;
    logic [63:0] put_value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] result_value;
  } rsp_t;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [63:0]     k1;
    logic [63:0]     k2;
    logic [63:0]     k3;
    logic [63:0]     value;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_CLEAR
  } state_e;

endpackage

// ===== hw/rtl/hashed_operation_result_cache_unit.sv =====
// Hashed operation result cache, top level: controller, hash unit and bucket memory.
// Depends on horc_pkg, horc_hash and horc_store.
//
// A get or put runs the serial FNV multiply over the three key words, then a
// memory read, a compare and an output register before its result strobe.
// Clear zeroes every bucket and then strobes a hit; the unused command strobes
// from idle without a hit. After reset a clearing pass zeroes the memory with
// busy high. The result strobe has no back-pressure; the receiver must take
// each result in its cycle.
module hashed_operation_result_cache_unit import horc_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output logic       done_o,
  output rsp_t       rsp_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);

  state_e state_q, state_d;
  req_t   req_q;
  logic [3:0] size_q;
  logic [LOG_DEPTH:0] clr_q, clr_d;
  logic [LOG_DEPTH-1:0] idx_q, idx_d, addr;
  logic [TagW-1:0] tag_q, tag_d;
  logic hstart, hdone;
  logic [63:0] hash;
  logic we;
  entry_t wdata, rdata;
  logic [LOG_DEPTH-1:0] mask;
  logic [4:0] eff;
  logic done_d;
  rsp_t rsp_d;
  logic acc;

  assign busy = (state_q != ST_IDLE);
  assign acc  = start && !busy;

  // Saturate the size into 1..LOG_DEPTH and build the index mask
  always_comb begin
    eff = {1'b0, size_q};
    if (eff < 5'd1) eff = 5'd1;
    if (32'(eff) > LOG_DEPTH) eff = 5'(LOG_DEPTH);
    mask = LOG_DEPTH'((64'd1 << eff) - 64'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= 4'd10;
    else if (cfg_we_i) size_q <= cfg_wdata_i;
  end

  horc_hash u_hash (
    .clk_i, .rst_ni, .start_i(hstart),
    .k1_i(req_q.key_first), .k2_i(req_q.key_second), .k3_i(req_q.key_third),
    .done_o(hdone), .hash_o(hash)
  );

  horc_store #(.LOG_DEPTH(LOG_DEPTH)) u_store (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (cmd_e'(req_i.command) == CMD_CLEAR) begin
            state_d = ST_CLEAR;
            clr_d   = '0;
          end else if (cmd_e'(req_i.command) != CMD_NONE) begin
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH:  if (hdone) state_d = ST_READ;
      ST_READ:  state_d = ST_CMP;
      ST_CMP:   state_d = ST_IDLE;
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (LOG_DEPTH+1)'(2**LOG_DEPTH - 1)) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    hstart = 1'b0;
    we     = 1'b0;
    addr   = idx_q;
    wdata  = '0;
    idx_d  = idx_q;
    tag_d  = tag_q;
    done_d = 1'b0;
    rsp_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        hstart = acc;
        if (acc && cmd_e'(req_i.command) == CMD_NONE) done_d = 1'b1;
      end
      ST_HASH: begin
        if (hdone) begin
          idx_d = hash[LOG_DEPTH-1:0] & mask;
          tag_d = hash[TagLsb +: TagW];
        end
      end
      ST_READ: begin
        if (cmd_e'(req_q.command) == CMD_PUT) begin
          we    = 1'b1;
          wdata = '{tag: tag_q, k1: req_q.key_first, k2: req_q.key_second,
                    k3: req_q.key_third, value: req_q.put_value};
        end
      end
      ST_CMP: begin
        done_d = 1'b1;
        if (cmd_e'(req_q.command) == CMD_PUT) begin
          rsp_d.hit = 1'b1;
        end else if (rdata.tag == tag_q && rdata.k1 == req_q.key_first &&
                     rdata.k2 == req_q.key_second && rdata.k3 == req_q.key_third) begin
          rsp_d.hit          = 1'b1;
          rsp_d.result_value = rdata.value;
        end
      end
      ST_CLEAR: begin
        we   = 1'b1;
        addr = clr_q[LOG_DEPTH-1:0];
        if (clr_q == (LOG_DEPTH+1)'(2**LOG_DEPTH - 1) && req_q.command == CMD_CLEAR) begin
          done_d    = 1'b1;
          rsp_d.hit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Hold control state and the accepted transaction; reset starts a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_o  <= 1'b0;
      req_q   <= '{command: CMD_NONE, default: '0};
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_o  <= done_d;
      if (acc) req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    tag_q <= tag_d;
    rsp_o <= rsp_d;
  end

endmodule

// ===== hw/rtl/horc_hash.sv =====
// Multi-cycle FNV-1a key hash: one 64x64 low-half multiply per step, three steps.
// Depends on horc_pkg.
module horc_hash import horc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] k1_i,
  input  logic [63:0] k2_i,
  input  logic [63:0] k3_i,
  output logic        done_o,
  output logic [63:0] hash_o
);

  logic [63:0] h_q, h_d;
  logic [1:0]  step_q, step_d;
  logic        run_q, run_d;
  logic [63:0] x;
  logic [63:0] p0, p1, p2;

  // Select the key word for this step and xor it in; the first step also folds
  // in the high half of the first key word
  always_comb begin
    case (step_q)
      2'd0:    x = h_q ^ {32'd0, k1_i[63:32]} ^ k1_i;
      2'd1:    x = h_q ^ k2_i;
      default: x = h_q ^ k3_i;
    endcase
  end

  // Low 64 bits of x * prime, prime is under 2^41: three 32x32-ish partials
  assign p0 = x[31:0] * FnvPrime[31:0];
  assign p1 = {x[31:0] * {23'd0, FnvPrime[40:32]}, 32'd0};
  assign p2 = {x[63:32] * FnvPrime[31:0], 32'd0};

  // Advance the hash one key word per cycle
  always_comb begin
    h_d    = h_q;
    step_d = step_q;
    run_d  = run_q;
    if (start_i) begin
      h_d    = FnvBasis;
      step_d = 2'd0;
      run_d  = 1'b1;
    end else if (run_q) begin
      h_d    = p0 + p1 + p2;
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= 2'd0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  assign done_o = run_q && (step_q == 2'd2);
  assign hash_o = h_d;

endmodule

// ===== hw/rtl/horc_store.sv =====
// Bucket memory: one synchronous port, registered read data.
// Depends on horc_pkg.
module horc_store import horc_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 10
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [LOG_DEPTH-1:0] addr_i,
  input  entry_t               wdata_i,
  output entry_t               rdata_o
);

  entry_t mem [2**LOG_DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== hw/rtl/horc_checker.sv =====
// Port-level checker for the hashed operation result cache, bound to the top level.
// Depends on horc_pkg.
module horc_assert_checker import horc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  // An accepted get or put raises busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.command == CMD_GET || req_i.command == CMD_PUT) |=> busy)
    else $error("busy not raised");

  // A miss returns zero
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.hit |-> rsp_o.result_value == 64'd0)
    else $error("miss with value");

  // An accepted unused command strobes next cycle without a hit
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.command == CMD_NONE |=> done_o && !rsp_o.hit)
    else $error("unused command not answered");

  // A strobe follows work in flight or an accepted transaction
  a_nostrobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("spurious strobe");

endmodule

bind hashed_operation_result_cache_unit horc_assert_checker u_horc_checker (.*);

// ===== verif/horc_checker.sv =====
// Checker for the hashed operation result cache: watches the command and result
// transactions, predicts each result and compares. Depends on horc_pkg.
`timescale 1ns / 100ps
module horc_checker import horc_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       busy,
  input  req_t       req_i,
  input  logic       done_o,
  input  rsp_t       rsp_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  output int         fail_count,
  output int         pending_count
);
  localparam int unsigned Depth = 1 << LOG_DEPTH;

  logic [3:0]  size_log2;
  entry_t      bucket_mem [Depth];
  rsp_t        expected_rsp_q [$];

  assign pending_count = expected_rsp_q.size();

  // FNV-1a over the three key words, with the high half of the first word folded in
  function automatic logic [63:0] fnv_mix(logic [63:0] k1, logic [63:0] k2,
                                          logic [63:0] k3);
    logic [63:0] h;
    h = FnvBasis ^ {32'd0, k1[63:32]};
    h = (h ^ k1) * FnvPrime;
    h = (h ^ k2) * FnvPrime;
    h = (h ^ k3) * FnvPrime;
    return h;
  endfunction

  // Bucket index with the size saturated into 1..LOG_DEPTH
  function automatic int unsigned bucket_of(logic [63:0] h);
    int unsigned lg;
    lg = size_log2;
    if (lg < 1) lg = 1;
    if (lg > LOG_DEPTH) lg = LOG_DEPTH;
    return int'(h & ((64'd1 << lg) - 64'd1));
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Predict one command transaction and update the model memory
  task automatic predict_access(req_t r);
    logic [63:0]      h;
    logic [TagW-1:0]  tg;
    int unsigned      idx;
    rsp_t             p;
    p = '0;
    case (cmd_e'(r.command))
      CMD_CLEAR: begin
        foreach (bucket_mem[i]) bucket_mem[i] = '0;
        p.hit = 1'b1;
      end
      CMD_GET, CMD_PUT: begin
        h = fnv_mix(r.key_first, r.key_second, r.key_third);
        tg = h[TagLsb +: TagW];
        idx = bucket_of(h);
        if (cmd_e'(r.command) == CMD_PUT) begin
          bucket_mem[idx] = '{tag: tg, k1: r.key_first, k2: r.key_second,
                              k3: r.key_third, value: r.put_value};
          p.hit = 1'b1;
        end else if (bucket_mem[idx].tag == tg && bucket_mem[idx].k1 == r.key_first &&
                     bucket_mem[idx].k2 == r.key_second &&
                     bucket_mem[idx].k3 == r.key_third) begin
          p.hit = 1'b1;
          p.result_value = bucket_mem[idx].value;
        end
      end
      default: ;
    endcase
    expected_rsp_q.push_back(p);
  endtask

  initial begin
    fail_count = 0;
    size_log2 = 4'd10;
    foreach (bucket_mem[i]) bucket_mem[i] = '0;
  end

  // Sample transactions at the rising edge; results are checked before new commands
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", {63'd0, rsp_o.hit}, 64'd0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_o.hit !== want.hit)
            report_mismatch("hit", {63'd0, rsp_o.hit}, {63'd0, want.hit});
          if (rsp_o.result_value !== want.result_value)
            report_mismatch("result_value", rsp_o.result_value, want.result_value);
        end
      end
      if (cfg_we_i) size_log2 = cfg_wdata_i;
      if (start && !busy) predict_access(req_i);
    end
  end
endmodule

// ===== verif/tb_hashed_operation_result_cache_unit.sv =====
// Testbench top for the hashed operation result cache: drives commands and size
// settings, and gives the verdict. Depends on horc_pkg and horc_checker.
`timescale 1ns / 100ps
module tb_hashed_operation_result_cache_unit;
  import horc_pkg::*;

  localparam int unsigned LogDepth = 10;
  localparam int unsigned RandomPerPhase = 280;

  logic       clk_i, rst_ni, start, busy, done_o, cfg_we_i;
  logic [3:0] cfg_wdata_i;
  req_t       req_i;
  rsp_t       rsp_o;
  int         fail_count, pending_count;

  logic [63:0] key_pool [8][3];

  hashed_operation_result_cache_unit #(.LOG_DEPTH(LogDepth)) dut (.*);
  horc_checker #(.LOG_DEPTH(LogDepth)) u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("FAIL hashed_operation_result_cache_unit");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random gap: mostly short, sometimes long
  task automatic idle_gap();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(2);
    repeat (n) @(negedge clk_i);
  endtask

  // Issue one command transaction and hold it until accepted
  task automatic send_cmd(cmd_e c, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3, logic [63:0] v, bit gaps);
    req_i = '{command: c, key_first: k1, key_second: k2, key_third: k3, put_value: v};
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start = 1'b0;
    if (gaps) idle_gap();
  endtask

  // Wait for all results, then let trailing work drain before a register write
  task automatic drain();
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_size(logic [3:0] lg);
    drain();
    cfg_wdata_i = lg;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random phase: mostly put/get on a small key pool, some noise
  task automatic random_phase(int n);
    int  sel, kind;
    bit  no_gaps;
    logic [63:0] k1, k2, k3;
    for (int i = 0; i < n; i++) begin
      no_gaps = (i / 60) % 3 == 2;
      sel = $urandom_range(7);
      kind = $urandom_range(99);
      k1 = key_pool[sel][0];
      k2 = key_pool[sel][1];
      k3 = key_pool[sel][2];
      if (kind < 8) k3 = rand64();
      if (kind < 3) begin
        k1 = rand64(); k2 = rand64();
      end
      if (kind < 40) send_cmd(CMD_PUT, k1, k2, k3, rand64(), !no_gaps);
      else if (kind < 94) send_cmd(CMD_GET, k1, k2, k3, rand64(), !no_gaps);
      else if (kind < 97) send_cmd(CMD_NONE, rand64(), rand64(), rand64(), rand64(), !no_gaps);
      else send_cmd(CMD_CLEAR, rand64(), rand64(), rand64(), rand64(), !no_gaps);
    end
  endtask

  initial begin
    logic [3:0] sizes [5];
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_i = '0;
    rst_ni = 1'b0;
    foreach (key_pool[i, j]) key_pool[i][j] = rand64();
    key_pool[0] = '{64'd0, 64'd0, 64'd0};
    key_pool[1] = '{'1, '1, '1};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty buckets, extremes, every command
    send_cmd(CMD_GET, '0, '0, '0, '0, 1'b0);
    send_cmd(CMD_GET, '1, '1, '1, '0, 1'b0);
    send_cmd(CMD_PUT, '1, '1, '1, '1, 1'b0);
    send_cmd(CMD_GET, '1, '1, '1, '0, 1'b0);
    send_cmd(CMD_PUT, '0, '0, '0, 64'h5555_aaaa_5555_aaaa, 1'b0);
    send_cmd(CMD_GET, '0, '0, '0, '1, 1'b0);
    send_cmd(CMD_GET, '1, '1, 64'd0, '0, 1'b0);
    send_cmd(CMD_NONE, '1, '1, '1, '1, 1'b0);
    send_cmd(CMD_CLEAR, '0, '0, '0, '0, 1'b0);
    send_cmd(CMD_GET, '1, '1, '1, '0, 1'b0);
    send_cmd(CMD_GET, '0, '0, '0, '0, 1'b0);

    // Sweep sizes: zero saturates up, fifteen saturates down
    sizes = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd10};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      send_cmd(CMD_CLEAR, rand64(), rand64(), rand64(), rand64(), 1'b1);
      random_phase(RandomPerPhase);
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS hashed_operation_result_cache_unit");
    end else begin
      $display("FAIL hashed_operation_result_cache_unit");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/horc_pkg.sv
hw/rtl/horc_hash.sv
hw/rtl/horc_store.sv
hw/rtl/hashed_operation_result_cache_unit.sv
hw/rtl/horc_checker.sv
verif/horc_checker.sv
verif/tb_hashed_operation_result_cache_unit.sv
